### rtl/cbsfa_pkg.sv
// ----------------------------------------------------------------------------
// CAN byte stream frame adapter package
// Shared widths, function codes and the controller/datapath handshake types.
// ----------------------------------------------------------------------------
package cbsfa_pkg;

	localparam int BYTE_W      = 8;
	localparam int TOTAL_W     = 12;
	localparam int LEN_W       = 4;
	localparam int FRAME_BYTES = 8;
	localparam int FRAME_W     = FRAME_BYTES * BYTE_W;
	localparam int POS_W       = 3;

	// Request function codes
	localparam logic [1:0] FUNC_SEND = 2'd0;
	localparam logic [1:0] FUNC_DONE = 2'd1;
	localparam logic [1:0] FUNC_RECV = 2'd2;
	localparam logic [1:0] FUNC_READ = 2'd3;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic cap;        // latch an accepted request, clear the result
		logic admit;      // size the send request from free space
		logic tx_wr;      // push the send byte if admission allows
		logic clr_busy;   // transmitter reports done
		logic tx_start;   // open a frame
		logic tx_rd;      // pop one transmit ring byte into the frame
		logic rx_wr;      // append one received byte
		logic rx_rd;      // pop one receive ring byte
		logic load_out;   // move the result into the output register
	} cbsfa_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic [1:0] func;
		logic       first;
		logic       last;
		logic       tx_go;
		logic       tx_more;
		logic       rx_more;
		logic       rx_nonempty;
		logic       out_free;
	} cbsfa_stat_t;

endpackage

### rtl/can_byte_stream_frame_adapter_top.sv
// ----------------------------------------------------------------------------
// CAN byte stream frame adapter
// Joins a byte stream to CAN frames through a transmit and a receive byte ring.
// ----------------------------------------------------------------------------
// Each request (send byte, transmit done, frame received, read byte) yields one
// result. Requests are handled one at a time. A first send byte is sized
// against the free transmit space; a last send byte or a transmit done may then
// open a frame and pack up to eight transmit ring bytes into it; a received
// frame appends its bytes to the receive ring; a read pops one byte if the
// receive ring is not empty. The ring sequencer moves one ring byte per cycle
// through the single write port and the registered read port of each ring RAM.
// A new request is taken as soon as the previous result sits in the output
// register, even while that result is still stalled. Both rings are
// 2^RING_ADDR_BITS bytes and hold one byte less than that; the receive ring has
// no overflow check.
// ----------------------------------------------------------------------------
module can_byte_stream_frame_adapter_top #(
	parameter int RING_ADDR_BITS = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      func,
	input  logic [cbsfa_pkg::BYTE_W-1:0]    send_byte,
	input  logic                            send_first,
	input  logic                            send_last,
	input  logic [cbsfa_pkg::TOTAL_W-1:0]   send_total,
	input  logic                            all_or_nothing,
	input  logic                            slot_free,
	input  logic [cbsfa_pkg::FRAME_W-1:0]   rx_frame_data,
	input  logic [cbsfa_pkg::LEN_W-1:0]     rx_frame_len,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            send_accepted,
	output logic [cbsfa_pkg::TOTAL_W-1:0]   bytes_left,
	output logic                            frame_valid,
	output logic [cbsfa_pkg::FRAME_W-1:0]   frame_data,
	output logic [cbsfa_pkg::LEN_W-1:0]     frame_len,
	output logic                            read_valid,
	output logic [cbsfa_pkg::BYTE_W-1:0]    read_byte,
	output logic                            data_available
);

	cbsfa_pkg::cbsfa_cmd_t  cmd;
	cbsfa_pkg::cbsfa_stat_t stat;

	cbsfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	cbsfa_dp #(
		.RING_ADDR_BITS (RING_ADDR_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.func           (func),
		.send_byte      (send_byte),
		.send_first     (send_first),
		.send_last      (send_last),
		.send_total     (send_total),
		.all_or_nothing (all_or_nothing),
		.slot_free      (slot_free),
		.rx_frame_data  (rx_frame_data),
		.rx_frame_len   (rx_frame_len),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.send_accepted  (send_accepted),
		.bytes_left     (bytes_left),
		.frame_valid    (frame_valid),
		.frame_data     (frame_data),
		.frame_len      (frame_len),
		.read_valid     (read_valid),
		.read_byte      (read_byte),
		.data_available (data_available)
	);

endmodule

### rtl/cbsfa_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cbsfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/cbsfa_ctrl.sv
// ----------------------------------------------------------------------------
// CAN byte stream frame adapter controller
// Sequences one request at a time through admission, ring access and result.
// ----------------------------------------------------------------------------
module cbsfa_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  cbsfa_pkg::cbsfa_stat_t stat,
	output cbsfa_pkg::cbsfa_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISP,
		S_ADMIT,
		S_WR,
		S_TX_CHK,
		S_TX_RD,
		S_RX_WR,
		S_RD,
		S_RD_WAIT,
		S_FIN
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   stall_q;
	logic   accept;

	assign in_stall = stall_q;
	assign accept   = in_valid && !stall_q;

	// Decode commands and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.cap = 1'b1;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				unique case (stat.func)
					cbsfa_pkg::FUNC_SEND: state_d = stat.first ? S_ADMIT : S_WR;
					cbsfa_pkg::FUNC_DONE: begin
						cmd.clr_busy = 1'b1;
						state_d      = S_TX_CHK;
					end
					cbsfa_pkg::FUNC_RECV: state_d = S_RX_WR;
					default:              state_d = S_RD;
				endcase
			end
			S_ADMIT: begin
				cmd.admit = 1'b1;
				state_d   = S_WR;
			end
			S_WR: begin
				cmd.tx_wr = 1'b1;
				state_d   = stat.last ? S_TX_CHK : S_FIN;
			end
			S_TX_CHK: begin
				if (stat.tx_go) begin
					cmd.tx_start = 1'b1;
					state_d      = S_TX_RD;
				end else begin
					state_d = S_FIN;
				end
			end
			S_TX_RD: begin
				if (stat.tx_more) begin
					cmd.tx_rd = 1'b1;
				end else begin
					state_d = S_FIN;
				end
			end
			S_RX_WR: begin
				if (stat.rx_more) begin
					cmd.rx_wr = 1'b1;
				end else begin
					state_d = S_FIN;
				end
			end
			S_RD: begin
				if (stat.rx_nonempty) begin
					cmd.rx_rd = 1'b1;
					state_d   = S_RD_WAIT;
				end else begin
					state_d = S_FIN;
				end
			end
			S_RD_WAIT: begin
				state_d = S_FIN;
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold state and the registered stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stall_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				stall_q <= 1'b1;
			end else if (state_q == S_FIN && stat.out_free) begin
				stall_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/cbsfa_dp.sv
// ----------------------------------------------------------------------------
// CAN byte stream frame adapter datapath
// Ring pointers, both byte rings, admission arithmetic, frame packing and the
// output register.
// ----------------------------------------------------------------------------
module cbsfa_dp #(
	parameter int RING_ADDR_BITS = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cbsfa_pkg::cbsfa_cmd_t           cmd,
	output cbsfa_pkg::cbsfa_stat_t          stat,
	input  logic [1:0]                      func,
	input  logic [cbsfa_pkg::BYTE_W-1:0]    send_byte,
	input  logic                            send_first,
	input  logic                            send_last,
	input  logic [cbsfa_pkg::TOTAL_W-1:0]   send_total,
	input  logic                            all_or_nothing,
	input  logic                            slot_free,
	input  logic [cbsfa_pkg::FRAME_W-1:0]   rx_frame_data,
	input  logic [cbsfa_pkg::LEN_W-1:0]     rx_frame_len,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            send_accepted,
	output logic [cbsfa_pkg::TOTAL_W-1:0]   bytes_left,
	output logic                            frame_valid,
	output logic [cbsfa_pkg::FRAME_W-1:0]   frame_data,
	output logic [cbsfa_pkg::LEN_W-1:0]     frame_len,
	output logic                            read_valid,
	output logic [cbsfa_pkg::BYTE_W-1:0]    read_byte,
	output logic                            data_available
);

	localparam int AW    = RING_ADDR_BITS;
	localparam int DEPTH = 1 << RING_ADDR_BITS;
	localparam int CW    = (AW > cbsfa_pkg::TOTAL_W) ? AW : cbsfa_pkg::TOTAL_W;

	// Request registers
	logic [1:0]                      func_q;
	logic [cbsfa_pkg::BYTE_W-1:0]    byte_q;
	logic                            first_q;
	logic                            last_q;
	logic [cbsfa_pkg::TOTAL_W-1:0]   total_q;
	logic                            aon_q;
	logic                            slot_q;
	logic [cbsfa_pkg::FRAME_W-1:0]   rxd_q;
	logic [cbsfa_pkg::LEN_W-1:0]     rxlen_q;

	// Ring state
	logic [AW-1:0]                   tx_wp_q;
	logic [AW-1:0]                   tx_rp_q;
	logic [AW-1:0]                   rx_wp_q;
	logic [AW-1:0]                   rx_rp_q;
	logic                            busy_q;
	logic [cbsfa_pkg::TOTAL_W-1:0]   admit_rem_q;

	// Result under construction
	logic                            acc_q;
	logic [cbsfa_pkg::TOTAL_W-1:0]   left_q;
	logic                            fvalid_q;
	logic [cbsfa_pkg::FRAME_W-1:0]   fdata_q;
	logic [cbsfa_pkg::LEN_W-1:0]     cnt_q;
	logic                            rvalid_q;
	logic [cbsfa_pkg::BYTE_W-1:0]    rbyte_q;

	// Read return tracking
	logic                            tx_pend_s1;
	logic [cbsfa_pkg::POS_W-1:0]     tx_pos_s1;
	logic                            rx_pend_s1;

	// Output register
	logic                            out_valid_q;

	logic [cbsfa_pkg::BYTE_W-1:0]    tx_rdata;
	logic [cbsfa_pkg::BYTE_W-1:0]    rx_rdata;
	logic                            tx_we;
	logic [AW-1:0]                   space;
	logic [CW-1:0]                   space_ext;
	logic [CW-1:0]                   total_ext;
	logic [cbsfa_pkg::TOTAL_W-1:0]   admit;
	logic [cbsfa_pkg::LEN_W-1:0]     rxlen_clamp;

	// Free space is the depth less one, less the queued count
	assign space     = tx_rp_q - tx_wp_q - AW'(1);
	assign space_ext = CW'(space);
	assign total_ext = CW'(total_q);

	always_comb begin
		if (space_ext < total_ext) begin
			admit = aon_q ? '0 : cbsfa_pkg::TOTAL_W'(space_ext);
		end else begin
			admit = total_q;
		end
	end

	// Clamp long receive lengths to one frame
	assign rxlen_clamp = (rx_frame_len > cbsfa_pkg::LEN_W'(cbsfa_pkg::FRAME_BYTES))
		? cbsfa_pkg::LEN_W'(cbsfa_pkg::FRAME_BYTES) : rx_frame_len;

	assign tx_we = cmd.tx_wr && (admit_rem_q != '0);

	// Status to the controller
	assign stat.func        = func_q;
	assign stat.first       = first_q;
	assign stat.last        = last_q;
	assign stat.tx_go       = !busy_q && slot_q && (tx_wp_q != tx_rp_q);
	assign stat.tx_more     = (cnt_q < cbsfa_pkg::LEN_W'(cbsfa_pkg::FRAME_BYTES))
		&& (tx_wp_q != tx_rp_q);
	assign stat.rx_more     = cnt_q < rxlen_q;
	assign stat.rx_nonempty = rx_wp_q != rx_rp_q;
	assign stat.out_free    = !out_valid_q || !out_stall;

	cbsfa_ram #(
		.WIDTH (cbsfa_pkg::BYTE_W),
		.DEPTH (DEPTH)
	) u_tx_ram (
		.clk   (clk),
		.we    (tx_we),
		.waddr (tx_wp_q),
		.wdata (byte_q),
		.re    (cmd.tx_rd),
		.raddr (tx_rp_q),
		.rdata (tx_rdata)
	);

	cbsfa_ram #(
		.WIDTH (cbsfa_pkg::BYTE_W),
		.DEPTH (DEPTH)
	) u_rx_ram (
		.clk   (clk),
		.we    (cmd.rx_wr),
		.waddr (rx_wp_q),
		.wdata (rxd_q[cbsfa_pkg::BYTE_W-1:0]),
		.re    (cmd.rx_rd),
		.raddr (rx_rp_q),
		.rdata (rx_rdata)
	);

	// Control state: pointers, busy flag, admission count, read returns
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_wp_q     <= '0;
			tx_rp_q     <= '0;
			rx_wp_q     <= '0;
			rx_rp_q     <= '0;
			busy_q      <= 1'b0;
			admit_rem_q <= '0;
			tx_pend_s1  <= 1'b0;
			rx_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			tx_pend_s1 <= cmd.tx_rd;
			rx_pend_s1 <= cmd.rx_rd;
			if (cmd.admit) begin
				admit_rem_q <= admit;
			end else if (tx_we) begin
				admit_rem_q <= admit_rem_q - cbsfa_pkg::TOTAL_W'(1);
			end
			if (tx_we) begin
				tx_wp_q <= tx_wp_q + AW'(1);
			end
			if (cmd.tx_rd) begin
				tx_rp_q <= tx_rp_q + AW'(1);
			end
			if (cmd.rx_wr) begin
				rx_wp_q <= rx_wp_q + AW'(1);
			end
			if (cmd.rx_rd) begin
				rx_rp_q <= rx_rp_q + AW'(1);
			end
			if (cmd.clr_busy) begin
				busy_q <= 1'b0;
			end else if (cmd.tx_start) begin
				busy_q <= 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Latch the request and build the result
	always_ff @(posedge clk) begin
		tx_pos_s1 <= cnt_q[cbsfa_pkg::POS_W-1:0];
		if (cmd.cap) begin
			func_q   <= func;
			byte_q   <= send_byte;
			first_q  <= send_first;
			last_q   <= send_last;
			total_q  <= send_total;
			aon_q    <= all_or_nothing;
			slot_q   <= slot_free;
			rxd_q    <= rx_frame_data;
			rxlen_q  <= rxlen_clamp;
			acc_q    <= 1'b0;
			left_q   <= '0;
			fvalid_q <= 1'b0;
			fdata_q  <= '0;
			cnt_q    <= '0;
			rvalid_q <= 1'b0;
			rbyte_q  <= '0;
		end
		if (cmd.admit) begin
			left_q <= total_q - admit;
		end
		if (tx_we) begin
			acc_q <= 1'b1;
		end
		if (cmd.tx_start) begin
			fvalid_q <= 1'b1;
		end
		if (cmd.tx_rd || cmd.rx_wr) begin
			cnt_q <= cnt_q + cbsfa_pkg::LEN_W'(1);
		end
		if (cmd.rx_wr) begin
			rxd_q <= rxd_q >> cbsfa_pkg::BYTE_W;
		end
		// Drop each returned transmit byte into its frame lane
		for (int i = 0; i < cbsfa_pkg::FRAME_BYTES; i++) begin
			if (tx_pend_s1 && tx_pos_s1 == cbsfa_pkg::POS_W'(i)) begin
				fdata_q[i*cbsfa_pkg::BYTE_W +: cbsfa_pkg::BYTE_W] <= tx_rdata;
			end
		end
		if (rx_pend_s1) begin
			rvalid_q <= 1'b1;
			rbyte_q  <= rx_rdata;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			send_accepted  <= acc_q;
			bytes_left     <= left_q;
			frame_valid    <= fvalid_q;
			frame_data     <= fdata_q;
			frame_len      <= fvalid_q ? cnt_q : '0;
			read_valid     <= rvalid_q;
			read_byte      <= rbyte_q;
			data_available <= rx_wp_q != rx_rp_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/cbsfa_checker.sv
// ----------------------------------------------------------------------------
// CAN byte stream frame adapter port checker
// Watches the top level ports for result consistency and output hold.
// ----------------------------------------------------------------------------
module cbsfa_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic                            send_accepted,
	input logic [cbsfa_pkg::TOTAL_W-1:0]   bytes_left,
	input logic                            frame_valid,
	input logic [cbsfa_pkg::FRAME_W-1:0]   frame_data,
	input logic [cbsfa_pkg::LEN_W-1:0]     frame_len,
	input logic                            read_valid,
	input logic [cbsfa_pkg::BYTE_W-1:0]    read_byte
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(frame_data)
			&& $stable(bytes_left) && $stable(read_byte) && $stable(send_accepted))
		else $error("stalled result changed");

	// A packed frame carries one to eight bytes
	a_frame_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_valid |-> frame_len != '0
			&& frame_len <= cbsfa_pkg::LEN_W'(cbsfa_pkg::FRAME_BYTES))
		else $error("frame length out of range");

	// No frame means an empty payload
	a_no_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_valid |-> frame_len == '0 && frame_data == '0)
		else $error("payload without frame");

	// No pop means a zero byte
	a_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !read_valid |-> read_byte == '0)
		else $error("read byte without pop");

endmodule

bind can_byte_stream_frame_adapter_top cbsfa_checker u_cbsfa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.send_accepted (send_accepted),
	.bytes_left    (bytes_left),
	.frame_valid   (frame_valid),
	.frame_data    (frame_data),
	.frame_len     (frame_len),
	.read_valid    (read_valid),
	.read_byte     (read_byte)
);
